// ===== src/pbtd_pkg.sv =====
// Package for the packet buffer tail-drop scheduler.
// Item types and fixed widths shared by the control and top level.
// No dependencies.
package pbtd_pkg;

   localparam int ARR_W  = 32;
   localparam int DUR_W  = 16;
   localparam int TIME_W = 48;
   localparam int CAP_W  = 7;

   localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

   typedef struct packed {
      logic [ARR_W-1:0] arrival_tick;
      logic [DUR_W-1:0] duration;
   } req_item_type;

   typedef struct packed {
      logic              dropped;
      logic [TIME_W-1:0] start_time;
   } rsp_item_type;

endpackage

// ===== src/packet_buffer_tail_drop_scheduler.sv =====
// Packet buffer with tail drop, single server: top level.
// Channels: req_ (arrival_tick, duration) in, rsp_ (dropped, start_time) out,
// csr_ writes the 7-bit buffer capacity (values above MAX_SLOTS act as MAX_SLOTS).
// One rsp item per req item, in order. Finish times of held packets live in a
// ring RAM of MAX_SLOTS entries with a registered read.
// Sequence: an accepted item goes straight to the decision step when the queue
// is empty; else the sequencer first pops the packets finished at that arrival,
// one per cycle through the RAM read port, until the head entry is unfinished or
// the queue is empty, then decides, and the result register loads from the
// decision step. Each packet is popped once. A new item is taken the cycle after
// the previous result is loaded.
// Reset (synchronous): queue empty, capacity 64, last finish time 0; the RAM
// needs no clearing since only counted entries are read.
// A stalled rsp_ channel holds its item in the output register; the sequencer
// waits in its decision step until the register frees, and req_ready stays low.
// Depends on pbtd_pkg, pbtd_ctrl, pbtd_ram.
module packet_buffer_tail_drop_scheduler #(
   parameter int MAX_SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pbtd_pkg::req_item_type        req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pbtd_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pbtd_pkg::CAP_W-1:0]    csr_data
);
   import pbtd_pkg::*;

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int OCC_W = $clog2(MAX_SLOTS + 1);

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              res_valid;
   logic              res_ready;
   rsp_item_type      res_item;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [TIME_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [TIME_W-1:0] ram_rd_data;
   logic [OCC_W-1:0]  occ_count;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);
   assign rsp_item_in  = res_valid ? res_item : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   pbtd_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .IDX_W     (IDX_W),
      .OCC_W     (OCC_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .capacity    (cap_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_item    (res_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .occ_count   (occ_count)
   );

   pbtd_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_SLOTS),
      .AW    (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (OCC_W + 1)'(occ_count) <= (OCC_W + 1)'(MAX_SLOTS))
      else $error("occupancy above ring depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in progress");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.dropped) |-> (rsp_item.start_time == '0))
      else $error("dropped item with nonzero start time");

   a_push_admitted: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (res_valid && !res_item.dropped))
      else $error("ring written without an admitted item");
`endif

endmodule

// ===== src/pbtd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pbtd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pbtd_ctrl.sv =====
// Sequencer of the tail-drop scheduler: head/tail pointers, occupancy and
// last finish time; pops finished entries from the ring RAM, then admits or drops.
// Depends on pbtd_pkg.
module pbtd_ctrl #(
   parameter int MAX_SLOTS = 64,
   parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
   parameter int OCC_W     = $clog2(MAX_SLOTS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pbtd_pkg::req_item_type              req_item,
   input  logic [pbtd_pkg::CAP_W-1:0]          capacity,
   output logic                                res_valid,
   input  logic                                res_ready,
   output pbtd_pkg::rsp_item_type              res_item,
   output logic                                ram_wr_en,
   output logic [IDX_W-1:0]                    ram_wr_addr,
   output logic [pbtd_pkg::TIME_W-1:0]         ram_wr_data,
   output logic [IDX_W-1:0]                    ram_rd_addr,
   input  logic [pbtd_pkg::TIME_W-1:0]         ram_rd_data,
   output logic [OCC_W-1:0]                    occ_count
);
   import pbtd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [1:0]        state_ff, state_in;
   logic [ARR_W-1:0]  arr_ff, arr_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic [IDX_W-1:0]  head_ff, head_in, head_next;
   logic [IDX_W-1:0]  tail_ff, tail_in, tail_next;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [TIME_W-1:0] last_ff, last_in;

   logic [TIME_W-1:0] arr_ext;
   logic [TIME_W-1:0] start;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] finish;
   logic              admit;
   logic              pop;

   assign head_next = (head_ff == IDX_W'(MAX_SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(MAX_SLOTS - 1)) ? '0 : tail_ff + 1'b1;

   assign arr_ext = TIME_W'(arr_ff);
   assign start   = ((occ_ff != '0) && (last_ff > arr_ext)) ? last_ff : arr_ext;
   assign sum     = {1'b0, start} + (TIME_W + 1)'(dur_ff);
   assign finish  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   assign admit   = (CMP_W'(occ_ff) < CMP_W'(capacity)) &&
                    (CMP_W'(occ_ff) < CMP_W'(MAX_SLOTS));
   assign pop     = (state_ff == ST_SCAN) && (ram_rd_data <= arr_ext);

   // Head entry is read every cycle; a pop advances the read one slot ahead.
   // A push lands at the tail before any read of that slot samples it, so no bypass.
   assign ram_rd_addr = pop ? head_next : head_ff;
   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = finish;
   assign occ_count   = occ_ff;

   always_comb begin
      state_in  = state_ff;
      arr_in    = arr_ff;
      dur_in    = dur_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      ram_wr_en = 1'b0;
      res_item.dropped    = !admit;
      res_item.start_time = admit ? start : '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               arr_in   = req_item.arrival_tick;
               dur_in   = req_item.duration;
               state_in = (occ_ff != '0) ? ST_SCAN : ST_DECIDE;
            end
         end
         ST_SCAN: begin
            if (pop) begin
               head_in = head_next;
               occ_in  = occ_ff - 1'b1;
               if (occ_ff == OCC_W'(1)) begin
                  state_in = ST_DECIDE;
               end
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               if (admit) begin
                  ram_wr_en = 1'b1;
                  tail_in   = tail_next;
                  occ_in    = occ_ff + 1'b1;
                  last_in   = finish;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         last_ff  <= last_in;
      end
      arr_ff <= arr_in;
      dur_ff <= dur_in;
   end

endmodule

// ===== sim/packet_buffer_tail_drop_scheduler_test.sv =====
// Self-checking testbench for packet_buffer_tail_drop_scheduler: a finish-time FIFO
// model predicts each start time or drop, checked against every rsp item.
// Depends on pbtd_pkg and the RTL top level.
module packet_buffer_tail_drop_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pbtd_pkg::*;

   localparam int SLOTS = 64;
   localparam int EXPECT_DEPTH = 64;
   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PRINT_LIMIT = 60;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 92;
   localparam logic [ARR_W-1:0] ARR_MAX = {ARR_W{1'b1}};
   localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_item_type req_item;
   logic rsp_valid;
   logic rsp_ready;
   rsp_item_type rsp_item;
   logic csr_valid;
   logic csr_ready;
   logic [CAP_W-1:0] csr_data;

   logic [TIME_W-1:0] held_finish[SLOTS];
   int held_head = 0;
   int held_count = 0;
   logic [TIME_W-1:0] newest_finish = '0;
   logic [CAP_W-1:0] capacity = CAP_RESET;
   rsp_item_type expected_rsp[EXPECT_DEPTH];
   int expected_head = 0;
   int expected_count = 0;
   rsp_item_type oldest_expected;

   int fail_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic [ARR_W-1:0] arrival_base = '0;

   packet_buffer_tail_drop_scheduler #(.MAX_SLOTS(SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic void add_expected(rsp_item_type item);
      expected_rsp[(expected_head + expected_count) % EXPECT_DEPTH] = item;
      expected_count++;
   endfunction

   function automatic rsp_item_type take_expected();
      rsp_item_type item;
      item = expected_rsp[expected_head];
      expected_head = (expected_head + 1) % EXPECT_DEPTH;
      expected_count--;
      return item;
   endfunction

   // Pops finished packets, then queues the new one or drops it.
   function automatic rsp_item_type schedule_packet(req_item_type pkt);
      rsp_item_type res;
      logic [TIME_W-1:0] start_t;
      logic [TIME_W:0] sum;
      int limit;
      limit = (int'(capacity) > SLOTS) ? SLOTS : int'(capacity);
      while (held_count > 0 && held_finish[held_head] <= TIME_W'(pkt.arrival_tick)) begin
         held_head = (held_head + 1) % SLOTS;
         held_count--;
      end
      if (held_count < limit) begin
         start_t = TIME_W'(pkt.arrival_tick);
         if (held_count > 0 && newest_finish > start_t) start_t = newest_finish;
         sum = {1'b0, start_t} + (TIME_W + 1)'(pkt.duration);
         newest_finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
         held_finish[(held_head + held_count) % SLOTS] = newest_finish;
         held_count++;
         res.dropped = 1'b0;
         res.start_time = start_t;
      end else begin
         res.dropped = 1'b1;
         res.start_time = '0;
      end
      return res;
   endfunction

   task automatic send_packet(input logic [ARR_W-1:0] arrival, input logic [DUR_W-1:0] dur);
      req_item_type pkt;
      pkt.arrival_tick = arrival;
      pkt.duration = dur;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= pkt;
      do @(posedge clock); while (!req_ready);
      add_expected(schedule_packet(pkt));
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (expected_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      capacity = value;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_count == 0) begin
            report_mismatch($sformatf("unexpected item dropped=%0b start=%0d",
                                      rsp_item.dropped, rsp_item.start_time));
         end else begin
            oldest_expected = take_expected();
            if (rsp_item.dropped !== oldest_expected.dropped)
               report_mismatch($sformatf("dropped got %0b want %0b",
                                         rsp_item.dropped, oldest_expected.dropped));
            if (rsp_item.start_time !== oldest_expected.start_time)
               report_mismatch($sformatf("start_time got %0d want %0d",
                                         rsp_item.start_time, oldest_expected.start_time));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("packet_buffer_tail_drop_scheduler regression: fail");
         $finish;
      end
   end

   task automatic test_reset_capacity;
      send_packet(32'd0, 16'd0);
      send_packet(32'd0, DUR_MAX);
      send_packet(32'd1, 16'd10);
      send_packet(32'd1, 16'd0);
      send_packet(32'd65545, 16'd7);
      send_packet(32'd65540, 16'd3);   // arrival steps back
      send_packet(32'd200000, 16'h5A5A);
      send_packet(32'd200000, 16'hA5A5);
   endtask

   task automatic test_zero_capacity;
      write_capacity(7'd0);
      send_packet(32'd250000, 16'd1);
      send_packet(32'd260000, 16'd0);
   endtask

   task automatic test_small_capacity;
      write_capacity(7'd2);
      repeat (4) send_packet(32'd300000, 16'd100);
      send_packet(32'd300150, 16'd20);
   endtask

   task automatic test_capacity_above_slots;
      write_capacity(7'd127);
      send_packet(32'd400000, 16'd50);
      send_packet(32'd400010, 16'd50);
      arrival_base = 32'd500000;
   endtask

   task automatic test_random_traffic;
      int cap_plan[PHASES] = '{64, 127, 1, 5, 65, 0, 32, 63};
      int scale_plan[PHASES] = '{16, 65535, 400, 16, 65535, 400, 5000, 16};
      int roll;
      int step;
      int dur_scale;
      logic [DUR_W-1:0] dur;
      logic [ARR_W-1:0] arrival;
      for (int phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
         write_capacity(phase == 5 ? CAP_W'($urandom_range(127, 0)) : CAP_W'(cap_plan[phase]));
         case (phase % 4)
            1: send_idle_pct = 57;
            2: rsp_stall_pct = 57;
            3: begin
               send_idle_pct = 29;
               rsp_stall_pct = 29;
            end
            default: ;
         endcase
         dur_scale = scale_plan[phase];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            roll = $urandom_range(99, 0);
            dur = DUR_W'($urandom_range(dur_scale, 0));
            // mostly bursts denser than service, so the buffer fills and drops
            if (roll < 70) step = $urandom_range(dur_scale / 4, 0);
            else if (roll < 95) step = $urandom_range(dur_scale * 2, 0);
            else if (roll < 99) step = $urandom_range(1 << 20, 0);
            else step = 0;
            arrival_base = (longint'(arrival_base) + step > longint'(ARR_MAX)) ?
                           ARR_MAX : arrival_base + ARR_W'(step);
            arrival = arrival_base;
            if (roll == 99 && arrival_base > ARR_W'(dur_scale))
               arrival = arrival_base - ARR_W'($urandom_range(dur_scale, 1));
            send_packet(arrival, dur);
            if (i == ITEMS_PER_PHASE / 2 || $urandom_range(199, 0) == 0) drain_results();
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_time_ceiling;
      write_capacity(7'd64);
      send_packet(ARR_MAX - 32'd70000, DUR_MAX);
      send_packet(ARR_MAX - 32'd70000, DUR_MAX);
      send_packet(ARR_MAX - 32'd1000, DUR_MAX);
      send_packet(ARR_MAX, DUR_MAX);
      send_packet(ARR_MAX, 16'd0);
      send_packet(ARR_MAX - 32'd1, 16'd1);
   endtask

   initial begin
      rsp_item_type missing;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_capacity();
      test_zero_capacity();
      test_small_capacity();
      test_capacity_above_slots();
      test_random_traffic();
      test_time_ceiling();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_count != 0) begin
         missing = take_expected();
         report_mismatch($sformatf("missing item dropped=%0b start=%0d",
                                   missing.dropped, missing.start_time));
      end
      if (fail_count == 0)
         $display("packet_buffer_tail_drop_scheduler regression: pass");
      else
         $display("packet_buffer_tail_drop_scheduler regression: fail");
      $finish;
   end
endmodule
